// ----- rtl/orl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orl_pkg
// Shared types and constants of the ordered record list.
// ----------------------------------------------------------------------------
package orl_pkg;

  localparam int KEY_W         = 16;
  localparam int VAL_W         = 24;
  localparam int KIND_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 5;
  localparam int DEPTH_DEFAULT = 16;

  // Stream widths: input tdata is key then value, output tdata is key, value, count.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [KIND_W-1:0] {
    OP_APPEND      = 3'd0,
    OP_INSERT      = 3'd1,
    OP_SEARCH      = 3'd2,
    OP_DELETE      = 3'd3,
    OP_REMOVE_HEAD = 3'd4,
    OP_REMOVE_TAIL = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
  } rec_t;

  typedef struct packed {
    status_t                status;
    logic [KEY_W-1:0]       found_key;
    logic [VAL_W-1:0]       found_value;
    logic [COUNT_OUT_W-1:0] entry_count;
  } result_t;

endpackage

// ----- rtl/orl_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orl_mem
// Record memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module orl_mem #(
  parameter int DEPTH = orl_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  orl_pkg::rec_t  wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output orl_pkg::rec_t  rdata
);
  import orl_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/orl_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orl_seq
// Operation sequencer: walks the record memory one entry per cycle, from the
// head or, on tail removal, from the last entry, shifting records up on insert and down on removal.
// ----------------------------------------------------------------------------
module orl_seq #(
  parameter int DEPTH = orl_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [orl_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [orl_pkg::KIND_W-1:0]        s_tuser,
  output logic                              res_valid,
  input  logic                              res_ready,
  output orl_pkg::result_t                  res,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output orl_pkg::rec_t                     mem_wdata,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_raddr,
  input  orl_pkg::rec_t                     mem_rdata
);
  import orl_pkg::*;

  state_t           state, state_next;
  op_t              op, op_next;
  logic [KEY_W-1:0] key, key_next;
  rec_t             carry, carry_next;
  logic [CW-1:0]    ptr, ptr_next;
  logic             pend, pend_next;
  logic [AW-1:0]    q, q_next;
  logic             active, active_next;
  logic [CW-1:0]    count, count_next;
  result_t          res_next;

  logic             issue;
  logic             hit;
  rec_t             in_rec;

  assign in_rec    = rec_t'(s_tdata);
  assign issue     = (state == S_SCAN) && (ptr < count);
  assign s_tready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign mem_re    = issue;
  assign mem_raddr = ptr[AW-1:0];

  // Entry seen in the current cycle meets the condition of the operation.
  always_comb begin
    hit = 1'b0;
    case (op)
      OP_INSERT:                  hit = pend && (mem_rdata.key >= key);
      OP_SEARCH, OP_DELETE:       hit = pend && (mem_rdata.key == key);
      OP_REMOVE_HEAD,
      OP_REMOVE_TAIL:             hit = pend;
      default:                    hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    key    <= key_next;
    carry  <= carry_next;
    ptr    <= ptr_next;
    q      <= q_next;
    active <= active_next;
    res    <= res_next;
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    key_next    = key;
    carry_next  = carry;
    ptr_next    = ptr;
    pend_next   = 1'b0;
    q_next      = q;
    active_next = active;
    count_next  = count;
    res_next    = res;
    mem_we      = 1'b0;
    mem_waddr   = q;
    mem_wdata   = carry;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_next     = op_t'(s_tuser);
          key_next    = in_rec.key;
          carry_next  = in_rec;
          active_next = 1'b0;
          ptr_next    = '0;
          res_next    = '{status: ST_OK, found_key: '0, found_value: '0,
                          entry_count: COUNT_OUT_W'(count)};
          state_next  = S_SCAN;
          case (s_tuser)
            OP_APPEND, OP_INSERT: begin
              if (count >= CW'(DEPTH)) begin
                res_next.status = ST_FULL;
                state_next      = S_DONE;
              end else if (s_tuser == OP_APPEND) begin
                // No walk: the record goes straight to the tail.
                ptr_next = count;
              end
            end
            OP_SEARCH, OP_DELETE, OP_REMOVE_HEAD: begin
              ptr_next = '0;
            end
            OP_REMOVE_TAIL: begin
              ptr_next = (count == '0) ? '0 : count - 1'b1;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        pend_next = issue;
        q_next    = ptr[AW-1:0];
        ptr_next  = ptr + CW'(issue);

        if (op == OP_APPEND || op == OP_INSERT) begin
          // Once the slot is found, every later entry moves up by one.
          if (pend && (active || hit)) begin
            mem_we      = 1'b1;
            mem_waddr   = q;
            mem_wdata   = carry;
            carry_next  = mem_rdata;
            active_next = 1'b1;
          end
          if (!pend && !issue) begin
            mem_we               = 1'b1;
            mem_waddr            = count[AW-1:0];
            mem_wdata            = carry;
            count_next           = count + 1'b1;
            res_next.entry_count = COUNT_OUT_W'(count_next);
            state_next           = S_DONE;
          end
        end else begin
          if (pend && active) begin
            // Close the gap left by the removed record.
            mem_we    = 1'b1;
            mem_waddr = q - 1'b1;
            mem_wdata = mem_rdata;
          end
          if (pend && !active && hit) begin
            active_next          = 1'b1;
            carry_next           = mem_rdata;
            if (op == OP_SEARCH) begin
              res_next.found_key   = mem_rdata.key;
              res_next.found_value = mem_rdata.value;
              state_next           = S_DONE;
            end
          end
          if (!pend && !issue) begin
            if (active) begin
              count_next           = count - 1'b1;
              res_next.found_key   = carry.key;
              res_next.found_value = carry.value;
            end else begin
              res_next.status = ST_MISS;
            end
            res_next.entry_count = COUNT_OUT_W'(count_next);
            state_next           = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/ordered_record_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_record_list
// Ordered list of up to DEPTH key/value records held in one memory.
// ----------------------------------------------------------------------------
// Full and unused kinds go straight to the result, an append writes the tail
// with no walk, and the other kinds walk the held records.
// One item is handled at a time, its time set by the walk over the record
// memory through its single read port, one entry a cycle.
// Reset clears the count, sequencer state and output valid; memory and output data are not cleared.
// A result waiting on the output does not block acceptance of the next item.
module ordered_record_list #(
  parameter int DEPTH = orl_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [orl_pkg::IN_TDATA_W-1:0]    s_tdata,  // record_key, record_value
  input  logic [orl_pkg::KIND_W-1:0]        s_tuser,  // kind
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [orl_pkg::OUT_TDATA_W-1:0]   m_tdata,  // found_key, found_value, entry_count
  output logic [orl_pkg::STATUS_W-1:0]      m_tuser   // status
);
  import orl_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          res_valid;
  logic          res_ready;
  result_t       res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rec_t          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  rec_t          mem_rdata;

  orl_seq #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  orl_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {3'b000, res.entry_count, res.found_value, res.found_key};
      m_tuser <= res.status;
    end
  end

endmodule

// ----- rtl/orl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orl_checker
// Port-level checks of the ordered record list, bound to the top level.
// ----------------------------------------------------------------------------
module orl_checker #(
  parameter int DEPTH = orl_pkg::DEPTH_DEFAULT
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [orl_pkg::IN_TDATA_W-1:0]    s_tdata,
  input logic [orl_pkg::KIND_W-1:0]        s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [orl_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic [orl_pkg::STATUS_W-1:0]      m_tuser
);
  import orl_pkg::*;

  // A stalled result holds its item.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_MISS))
    else $error("undefined status code");

  // A failed operation returns no record.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[IN_TDATA_W-1:0] == '0)
    else $error("record returned with a failing status");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && DEPTH < 32 |-> 32'(m_tdata[44:40]) <= DEPTH)
    else $error("entry count above depth");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

endmodule

bind ordered_record_list orl_checker #(.DEPTH(DEPTH)) u_orl_checker (.*);
